// ----- rtl/pcqat_pkg.sv -----
// ----------------------------------------------------------------------------
// Per-client QoS admission table package
// Shared widths, operation and register codes, and the table entry and
// configuration structures.
// ----------------------------------------------------------------------------
package pcqat_pkg;

   // Table size and the address width it needs.
   localparam int ClientCount = 64;
   localparam int ClientIdxW  = (ClientCount > 1) ? $clog2(ClientCount) : 1;

   // Field widths of the request and response transfers.
   localparam int FuncW     = 2;
   localparam int ClientW   = 6;
   localparam int ByteCntW  = 20;
   localparam int TimeW     = 32;
   localparam int ActiveW   = 16;
   localparam int WinBytesW = 32;

   // Configuration port widths.
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 32;

   // Operation codes.
   localparam logic [FuncW-1:0] FuncAdmit   = 2'd0;
   localparam logic [FuncW-1:0] FuncRelease = 2'd1;
   localparam logic [FuncW-1:0] FuncSend    = 2'd2;

   // Configuration register indexes.
   localparam logic [CsrIndexW-1:0] CsrMaxActive      = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrMaxWindowBytes = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrWindowTicks    = 2'd2;

   // Configuration reset values.
   localparam logic [ActiveW-1:0]   MaxActiveRst      = 16'd4;
   localparam logic [WinBytesW-1:0] MaxWindowBytesRst = 32'd1048576;
   localparam logic [TimeW-1:0]     WindowTicksRst    = 32'd100000000;

   // One client's entry in the table.
   typedef struct packed {
      logic [ActiveW-1:0]   active;
      logic [WinBytesW-1:0] bytes;
      logic [TimeW-1:0]     start;
   } entry_type;

   // Limits applied by the update logic.
   typedef struct packed {
      logic [ActiveW-1:0]   max_active;
      logic [WinBytesW-1:0] max_window_bytes;
      logic [TimeW-1:0]     window_ticks;
   } cfg_type;

endpackage

// ----- rtl/pcqat_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one admission table operation.
// ----------------------------------------------------------------------------
interface pcqat_req_if;
   logic                           valid;
   logic                           ready;
   logic [pcqat_pkg::FuncW-1:0]    func;
   logic [pcqat_pkg::ClientW-1:0]  client;
   logic [pcqat_pkg::ByteCntW-1:0] byte_count;
   logic [pcqat_pkg::TimeW-1:0]    now_time;

   modport source (output valid, func, client, byte_count, now_time, input ready);
   modport sink   (input valid, func, client, byte_count, now_time, output ready);
endinterface

// ----- rtl/pcqat_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one admission decision and the entry state.
// ----------------------------------------------------------------------------
interface pcqat_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            granted;
   logic [pcqat_pkg::ActiveW-1:0]   active_after;
   logic [pcqat_pkg::WinBytesW-1:0] window_bytes_after;

   modport source (output valid, granted, active_after, window_bytes_after, input ready);
   modport sink   (input valid, granted, active_after, window_bytes_after, output ready);
endinterface

// ----- rtl/per_client_qos_admission_table.sv -----
// ----------------------------------------------------------------------------
// Per-client QoS admission table
// Fixed-window rate limiter with an active-request count per client.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one operation (admit, release or send) for one
//   client with a byte count and the current time stamp. The rsp channel
//   returns one transfer per request: the grant flag and the client's active
//   count and window byte total after the operation. Both are valid/ready.
//   The user must write limits through the csr port only while the block
//   is idle; the block does not enforce this. A request is registered in
//   the update stage, its result in the output register. Unless the response
//   side stalls, one request is taken each cycle; the rate is set by the single
//   table read and write per item, with a bypass from the update stage back
//   to the read register for back-to-back requests to the same client.
//   Reset clears the limits to their defaults and empties the table at once
//   through per-entry valid bits, so no clearing pass is needed. When the
//   response receiver stalls, the output register holds its transfer, the
//   update stage holds one more item, and req.ready then drops.
// ----------------------------------------------------------------------------
module per_client_qos_admission_table (
   input  logic                             clock,
   input  logic                             reset,
   pcqat_req_if.sink                        req_ch,
   pcqat_rsp_if.source                      rsp_ch,
   input  logic                             csr_we,
   input  logic [pcqat_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [pcqat_pkg::CsrDataW-1:0]   csr_wdata
);

   // Configuration registers.
   pcqat_pkg::cfg_type cfg_ff;

   // Update stage registers.
   logic                            s1_valid_ff;
   logic [pcqat_pkg::FuncW-1:0]     s1_func_ff;
   logic [pcqat_pkg::ClientW-1:0]   s1_client_ff;
   logic [pcqat_pkg::ByteCntW-1:0]  s1_bytes_ff;
   logic [pcqat_pkg::TimeW-1:0]     s1_now_ff;
   pcqat_pkg::entry_type            rd_entry_ff;
   logic                            rd_hit_ff;

   // Table storage and its valid bits.
   pcqat_pkg::entry_type            tbl_mem [pcqat_pkg::ClientCount];
   logic [pcqat_pkg::ClientCount-1:0] entry_valid_ff;

   // Output register.
   logic                            rsp_valid_ff;
   logic                            rsp_granted_ff;
   logic [pcqat_pkg::ActiveW-1:0]   rsp_active_ff;
   logic [pcqat_pkg::WinBytesW-1:0] rsp_bytes_ff;

   // Combinational signals.
   logic                                s1_adv;
   logic                                req_fire;
   logic                                s1_in_range;
   logic                                wr_en;
   logic                                bypass;
   logic [pcqat_pkg::ClientIdxW-1:0]    rd_addr;
   logic [pcqat_pkg::ClientIdxW-1:0]    wr_addr;
   pcqat_pkg::entry_type                cur_entry;
   pcqat_pkg::entry_type                upd_entry;
   logic                                upd_granted;

   // Handshake control.
   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Addressing and the write-back enable.
   assign rd_addr     = pcqat_pkg::ClientIdxW'(req_ch.client);
   assign wr_addr     = pcqat_pkg::ClientIdxW'(s1_client_ff);
   assign s1_in_range = (int'(s1_client_ff) < pcqat_pkg::ClientCount);
   assign wr_en       = s1_adv && s1_in_range;
   assign bypass      = wr_en && (req_ch.client == s1_client_ff);

   // An entry never written reads as zero.
   assign cur_entry = rd_hit_ff ? rd_entry_ff : '0;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_active       <= pcqat_pkg::MaxActiveRst;
         cfg_ff.max_window_bytes <= pcqat_pkg::MaxWindowBytesRst;
         cfg_ff.window_ticks     <= pcqat_pkg::WindowTicksRst;
      end else if (csr_we) begin
         case (csr_index)
            pcqat_pkg::CsrMaxActive: begin
               cfg_ff.max_active <= csr_wdata[pcqat_pkg::ActiveW-1:0];
            end
            pcqat_pkg::CsrMaxWindowBytes: begin
               cfg_ff.max_window_bytes <= csr_wdata[pcqat_pkg::WinBytesW-1:0];
            end
            pcqat_pkg::CsrWindowTicks: begin
               cfg_ff.window_ticks <= csr_wdata[pcqat_pkg::TimeW-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Update stage valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Request capture and table read, with the bypass from the item being
   // written back in the same cycle.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff   <= req_ch.func;
         s1_client_ff <= req_ch.client;
         s1_bytes_ff  <= req_ch.byte_count;
         s1_now_ff    <= req_ch.now_time;
         if (bypass) begin
            rd_entry_ff <= upd_entry;
            rd_hit_ff   <= 1'b1;
         end else begin
            rd_entry_ff <= tbl_mem[rd_addr];
            rd_hit_ff   <= entry_valid_ff[rd_addr];
         end
      end
   end

   // Table write-back.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= upd_entry;
      end
   end

   // Valid bits empty the table at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (wr_en) begin
         entry_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Entry update logic.
   pcqat_update u_update (
      .func       (s1_func_ff),
      .byte_count (s1_bytes_ff),
      .now_time   (s1_now_ff),
      .cur        (cur_entry),
      .cfg        (cfg_ff),
      .nxt        (upd_entry),
      .granted    (upd_granted)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         if (s1_in_range) begin
            rsp_granted_ff <= upd_granted;
            rsp_active_ff  <= upd_entry.active;
            rsp_bytes_ff   <= upd_entry.bytes;
         end else begin
            rsp_granted_ff <= 1'b0;
            rsp_active_ff  <= '0;
            rsp_bytes_ff   <= '0;
         end
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.granted            = rsp_granted_ff;
   assign rsp_ch.active_after       = rsp_active_ff;
   assign rsp_ch.window_bytes_after = rsp_bytes_ff;

`ifndef SYNTHESIS
   // The request side only stalls behind a full update stage and output.
   assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ch.ready))
      else $error("request stalled without a full pipeline");

   // A back-to-back request to the same client sees the value just written.
   assert property (@(posedge clock) disable iff (reset)
      bypass && req_fire |=> (cur_entry == $past(upd_entry)))
      else $error("bypass did not forward the written entry");

   // A release is always granted.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_in_range && (s1_func_ff == pcqat_pkg::FuncRelease)
      |-> upd_granted)
      else $error("release not granted");

   // A granted admit raises the count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (s1_func_ff == pcqat_pkg::FuncAdmit) && upd_granted
      |-> (upd_entry.active == cur_entry.active + 1'b1))
      else $error("granted admit did not increment the count");
`endif

endmodule

// ----- rtl/pcqat_update.sv -----
// ----------------------------------------------------------------------------
// Admission table entry update
// Computes the grant decision and the new entry for one operation.
// ----------------------------------------------------------------------------
module pcqat_update (
   input  logic [pcqat_pkg::FuncW-1:0]    func,
   input  logic [pcqat_pkg::ByteCntW-1:0] byte_count,
   input  logic [pcqat_pkg::TimeW-1:0]    now_time,
   input  pcqat_pkg::entry_type           cur,
   input  pcqat_pkg::cfg_type             cfg,
   output pcqat_pkg::entry_type           nxt,
   output logic                           granted
);

   logic [pcqat_pkg::TimeW-1:0]     elapsed;
   logic                            expired;
   logic [pcqat_pkg::WinBytesW:0]   sum_keep;
   logic                            ok_keep;
   logic                            ok_new;
   logic [pcqat_pkg::WinBytesW-1:0] bytes_ext;

   // Window check, the byte sum and both byte checks are formed side by side.
   assign elapsed   = now_time - cur.start;
   assign expired   = (elapsed >= cfg.window_ticks);
   assign bytes_ext = pcqat_pkg::WinBytesW'(byte_count);
   assign sum_keep  = {1'b0, cur.bytes} + {1'b0, bytes_ext};
   assign ok_keep   = (sum_keep <= {1'b0, cfg.max_window_bytes});
   assign ok_new    = (bytes_ext <= cfg.max_window_bytes);

   // Select the result for the operation.
   always_comb begin
      nxt     = cur;
      granted = 1'b0;
      case (func)
         pcqat_pkg::FuncAdmit: begin
            if (cur.active < cfg.max_active) begin
               nxt.active = cur.active + 1'b1;
               granted    = 1'b1;
            end
         end
         pcqat_pkg::FuncRelease: begin
            if (cur.active != '0) begin
               nxt.active = cur.active - 1'b1;
            end
            granted = 1'b1;
         end
         pcqat_pkg::FuncSend: begin
            if (expired) begin
               // A new window opens before the byte check.
               nxt.start = now_time;
               nxt.bytes = ok_new ? bytes_ext : '0;
               granted   = ok_new;
            end else begin
               nxt.bytes = ok_keep ? sum_keep[pcqat_pkg::WinBytesW-1:0] : cur.bytes;
               granted   = ok_keep;
            end
         end
         default: begin
            nxt     = cur;
            granted = 1'b0;
         end
      endcase
   end

endmodule
